// ----- rtl/tata_pkg.sv -----
// Package for the table arctangent block: widths, constants, tangent table,
// command and status types shared by controller and datapath.
// No dependencies.
package tata_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int TAN_LAST   = 44;
    localparam int IDX_W      = 6;
    localparam int SRCH_STEPS = IDX_W;
    localparam int SCNT_W     = 3;
    localparam int OPND_W     = 32;
    localparam int DIV_W      = OPND_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int TV_W       = FRAC_BITS + 1;
    localparam int DEG_W      = 26;
    localparam int ANG_W      = 25;
    localparam int RQ_W       = FRAC_BITS + 3;
    localparam int PROD_W     = OPND_W + TV_W;
    localparam int RAD_W      = 24;
    localparam int RAD_SHIFT  = 31;

    localparam logic signed [DEG_W-1:0] DEG90  = DEG_W'(90 <<< FRAC_BITS);
    localparam logic signed [DEG_W-1:0] DEG180 = DEG_W'(180 <<< FRAC_BITS);
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic signed [RQ_W-1:0] PI_FIX = RQ_W'(PI_Q60 >> (60 - FRAC_BITS));
    // ceil(2^31 / 180): exact floor division by 180 for magnitudes below 2^24
    localparam logic [RAD_W-1:0] RAD_RECIP = RAD_W'((64'd1 << RAD_SHIFT) / 64'd180 + 64'd1);

    localparam logic [31:0] TAN_TBL [TAN_LAST+1] = '{
        32'h00000000, 32'h0477ef65, 32'h08f0914b, 32'h0d6a98a2, 32'h11e6b93a,
        32'h1665a835, 32'h1ae81c75, 32'h1f6ecf1a, 32'h23fa7bf1, 32'h288be1f7,
        32'h2d23c3d8, 32'h31c2e86f, 32'h366a1b59, 32'h3b1a2d83, 32'h3fd3f5c2,
        32'h4498517a, 32'h49682546, 32'h4e445dae, 32'h532defed, 32'h5825dabe,
        32'h5d2d273d, 32'h6244e9d5, 32'h676e4343, 32'h6caa61ae, 32'h71fa81d3,
        32'h775ff04e, 32'h7cdc0afd, 32'h82704286, 32'h881e1bfc, 32'h8de732b0,
        32'h93cd3a2d, 32'h99d20064, 32'h9ff77017, 32'ha63f9377, 32'hacac9715,
        32'hb340cd1d, 32'hb9feb0ed, 32'hc0e8eb11, 32'hc80255b7, 32'hcf4e01a3,
        32'hd6cf3bc2, 32'hde89935e, 32'he680e123, 32'heeb94f06, 32'hf737612a
    };

    // tan of whole degrees; entry 45 is exactly 1.0
    function automatic logic [TV_W-1:0] tan_at(input logic [IDX_W-1:0] i);
        logic [TV_W-1:0] t;
        if (i > IDX_W'(TAN_LAST)) begin
            t = TV_W'(1) << FRAC_BITS;
        end else begin
            t = TV_W'(TAN_TBL[i] >> (32 - FRAC_BITS));
        end
        return t;
    endfunction

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ZERO,
        OP_DIV_Q,
        OP_RATIO,
        OP_DIV_REC,
        OP_RECIP,
        OP_SRCH_STEP,
        OP_DIV_SLP,
        OP_MUL,
        OP_QUAD,
        OP_DIV_RAD,
        OP_RAD_MUL,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic in_ready;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic x_zero;
        logic ratio_ge_one;
        logic div_done;
        logic rad;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/tata_if.sv -----
// Handshake channel interfaces for the table arctangent block.
// Depends on tata_pkg for field widths.
interface tata_in_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] numerator;
    logic signed [31:0] denominator;
    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface tata_out_if;
    logic        valid;
    logic        ready;
    logic signed [tata_pkg::ANG_W-1:0] angle;
    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface tata_cfg_if;
    logic valid;
    logic ready;
    logic angle_in_radians;
    modport source (output valid, output angle_in_radians, input ready);
    modport sink   (input valid, input angle_in_radians, output ready);
endinterface

// ----- rtl/tata_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tata_pkg.
module tata_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tata_pkg::DIV_W-1:0]     i_dividend,
    input  logic [tata_pkg::OPND_W-1:0]    i_divisor,
    output logic [tata_pkg::DIV_W-1:0]     o_quot,
    output logic                           o_done
);
    import tata_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_q;
    logic [OPND_W-1:0]    r_rem;
    logic [OPND_W-1:0]    r_d;
    logic [OPND_W:0]      sh;
    logic [OPND_W:0]      sub;
    logic                 ge;

    always_comb begin
        sh  = {r_rem, r_q[DIV_W-1]};
        sub = sh - {1'b0, r_d};
        ge  = sh >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_d    <= i_divisor;
                r_cnt  <= DIV_CNT_W'(DIV_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[DIV_W-2:0], ge};
                r_rem <= ge ? sub[OPND_W-1:0] : sh[OPND_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

// ----- rtl/tata_dp.sv -----
// Datapath: operand registers, divider, table search, interpolation,
// quadrant and radian steps, config register and output register.
// Depends on tata_pkg, tata_if and tata_div.
module tata_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tata_pkg::t_cmd i_cmd,
    output tata_pkg::t_sts o_sts,
    tata_in_if.sink        i_in,
    tata_out_if.source     o_out,
    tata_cfg_if.sink       i_cfg
);
    import tata_pkg::*;

    logic                    r_ysgn, r_xsgn, r_xz, r_over, r_rad, r_ov;
    logic [OPND_W-1:0]       r_my, r_mx;
    logic [30:0]             r_ratio;
    logic [TV_W-1:0]         r_v, r_frac, r_diff;
    logic [IDX_W-1:0]        r_idx, r_sbit;
    logic [PROD_W-1:0]       r_prod;
    logic signed [DEG_W-1:0] r_deg;
    logic [ANG_W-1:0]        r_oang;
    logic [RQ_W-1:0]         r_rq;

    logic                    div_start, div_done;
    logic [DIV_W-1:0]        dividend, quot;
    logic [OPND_W-1:0]       divisor;
    logic [30:0]             qsat;
    logic [IDX_W-1:0]        cand;
    logic [TV_W-1:0]         t_lo, diff_c;
    logic signed [DEG_W-1:0] d, dq, abs_deg;
    logic signed [RQ_W-1:0]  rq;
    logic signed [2*RQ_W-1:0] rprod;
    logic [2*RAD_W-1:0]      rad_prod;
    logic [DIV_W-1:0]        one_sq;

    always_comb begin
        one_sq  = DIV_W'(1) << (2 * FRAC_BITS);
        t_lo    = tan_at(r_idx);
        diff_c  = tan_at(r_idx + 1'b1) - t_lo;
        abs_deg = r_deg[DEG_W-1] ? -r_deg : r_deg;
        div_start = 1'b1;
        dividend  = one_sq;
        divisor   = '0;
        case (i_cmd.op)
            OP_DIV_Q: begin
                dividend = {r_my, FRAC_BITS'(0)};
                divisor  = r_mx;
            end
            OP_DIV_REC: divisor = {1'b0, r_ratio};
            OP_DIV_SLP: divisor = OPND_W'(diff_c);
            default: div_start = 1'b0;
        endcase
        qsat = (|quot[DIV_W-1:31]) ? '1 : quot[30:0];
        cand = r_idx | r_sbit;
        d    = DEG_W'({r_idx, FRAC_BITS'(0)}) + DEG_W'(r_prod >> FRAC_BITS);
        if (r_over) begin
            d = DEG90 - d;
        end
        if (!r_ysgn && !r_xsgn) begin
            dq = d;
        end else if (!r_ysgn) begin
            dq = DEG180 - d;
        end else if (r_xsgn) begin
            dq = d - DEG180;
        end else begin
            dq = -d;
        end
        // degrees / 180 by reciprocal multiplication
        rad_prod = abs_deg[RAD_W-1:0] * RAD_RECIP;
        rq    = r_deg[DEG_W-1] ? -RQ_W'(r_rq) : RQ_W'(r_rq);
        rprod = PI_FIX * rq;
    end

    tata_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_quot     (quot),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_rad <= i_cfg.angle_in_radians;
            end
            if (i_cmd.op == OP_OUT) begin
                r_ov   <= 1'b1;
                r_oang <= r_deg[ANG_W-1:0];
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
        if (i_in.valid && i_cmd.in_ready) begin
            r_ysgn <= i_in.numerator[31];
            r_xsgn <= i_in.denominator[31];
            r_xz   <= i_in.denominator == '0;
            r_my   <= i_in.numerator[31] ? -i_in.numerator : i_in.numerator;
            r_mx   <= i_in.denominator[31] ? -i_in.denominator : i_in.denominator;
        end
        case (i_cmd.op)
            OP_ZERO: r_deg <= r_ysgn ? -DEG90 : DEG90;
            OP_RATIO: begin
                r_ratio <= qsat;
                r_v     <= qsat[TV_W-1:0];
                r_over  <= 1'b0;
                r_idx   <= '0;
                r_sbit  <= IDX_W'(1) << (IDX_W - 1);
            end
            OP_RECIP: begin
                r_v    <= quot[TV_W-1:0];
                r_over <= 1'b1;
                r_idx  <= '0;
                r_sbit <= IDX_W'(1) << (IDX_W - 1);
            end
            OP_SRCH_STEP: begin
                if (cand <= IDX_W'(TAN_LAST) && tan_at(cand) <= r_v) begin
                    r_idx <= cand;
                end
                r_sbit <= r_sbit >> 1;
            end
            OP_DIV_SLP: begin
                r_frac <= r_v - t_lo;
                r_diff <= diff_c;
            end
            OP_MUL: r_prod <= (r_diff == '0) ? '0 : quot[OPND_W-1:0] * r_frac;
            OP_QUAD: r_deg <= dq;
            OP_DIV_RAD: r_rq <= RQ_W'(rad_prod >> RAD_SHIFT);
            OP_RAD_MUL: r_deg <= DEG_W'(rprod >>> FRAC_BITS);
            default: ;
        endcase
    end

    assign i_in.ready  = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.angle = r_oang;

    // taken from the quotient so the check sees the ratio being loaded
    assign o_sts.x_zero       = r_xz;
    assign o_sts.ratio_ge_one = |qsat[30:FRAC_BITS];
    assign o_sts.div_done     = div_done;
    assign o_sts.rad          = r_rad;
    assign o_sts.out_free     = !r_ov || o_out.ready;

endmodule

// ----- rtl/tata_ctrl.sv -----
// Controller: sequences divisions, table search and result steps.
// Depends on tata_pkg.
module tata_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  tata_pkg::t_sts i_sts,
    output tata_pkg::t_cmd o_cmd
);
    import tata_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ZCHK, S_DQ, S_RCHK, S_DR, S_SRCH, S_SLOPE, S_DS,
        S_MUL, S_RADCHK, S_DRAD, S_RMUL, S_OUT
    } t_state;

    t_state            r_state;
    logic              r_in_ready;
    t_op               r_op;
    logic [SCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
            r_op       <= OP_NONE;
            r_cnt      <= '0;
        end else begin
            r_op <= OP_NONE;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_in_ready <= 1'b0;
                        r_state    <= S_ZCHK;
                    end
                end
                S_ZCHK: begin
                    if (i_sts.x_zero) begin
                        r_op    <= OP_ZERO;
                        r_state <= S_RADCHK;
                    end else begin
                        r_op    <= OP_DIV_Q;
                        r_state <= S_DQ;
                    end
                end
                S_DQ: begin
                    if (i_sts.div_done) begin
                        r_op    <= OP_RATIO;
                        r_state <= S_RCHK;
                    end
                end
                S_RCHK: begin
                    r_cnt <= '0;
                    if (i_sts.ratio_ge_one) begin
                        r_op    <= OP_DIV_REC;
                        r_state <= S_DR;
                    end else begin
                        r_state <= S_SRCH;
                    end
                end
                S_DR: begin
                    if (i_sts.div_done) begin
                        r_op    <= OP_RECIP;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    r_op  <= OP_SRCH_STEP;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == SCNT_W'(SRCH_STEPS - 1)) begin
                        r_state <= S_SLOPE;
                    end
                end
                S_SLOPE: begin
                    r_op    <= OP_DIV_SLP;
                    r_state <= S_DS;
                end
                S_DS: begin
                    if (i_sts.div_done) begin
                        r_op    <= OP_MUL;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_op    <= OP_QUAD;
                    r_state <= S_RADCHK;
                end
                S_RADCHK: begin
                    if (i_sts.rad) begin
                        r_op    <= OP_DIV_RAD;
                        r_state <= S_DRAD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DRAD: begin
                    r_op    <= OP_RAD_MUL;
                    r_state <= S_RMUL;
                end
                S_RMUL: r_state <= S_OUT;
                S_OUT: begin
                    if (i_sts.out_free) begin
                        r_op       <= OP_OUT;
                        r_in_ready <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd.in_ready = r_in_ready;
    assign o_cmd.op       = r_op;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> r_state == S_IDLE)
        else $error("input ready outside idle");
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_DQ || r_state == S_DR ||
                            r_state == S_DS || r_state == S_DRAD))
        else $error("divider finished while not awaited");
    a_srch_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SRCH |-> r_cnt < SCNT_W'(SRCH_STEPS))
        else $error("search step count overrun");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op == OP_OUT |-> $past(r_state) == S_OUT)
        else $error("result load outside output state");
`endif

endmodule

// ----- rtl/table_arctangent_two_argument.sv -----
// Top level of the table arctangent block: controller plus datapath.
// Depends on tata_pkg, tata_if, tata_ctrl, tata_dp.
//
//  channel | direction | payload
//  i_in    | sink      | numerator, denominator (32 bit signed)
//  o_out   | source    | angle (25 bit signed)
//  i_cfg   | sink      | angle_in_radians (1 bit)
//
// One item at a time: the next input is taken once the result is loaded;
// a zero denominator skips the divider and search, else there are two divider
// passes (three for a ratio of one or more), six search steps, multiply and
// quadrant. Radians add a scaling by 1/180 and a multiply by pi. Reset returns
// to idle with degrees selected. A result waiting in the output register
// holds back the next result load, and the input with it.
module table_arctangent_two_argument (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tata_in_if.sink    i_in,
    tata_out_if.source o_out,
    tata_cfg_if.sink   i_cfg
);
    import tata_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tata_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tata_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg)
    );

endmodule

// ----- bench/table_arctangent_two_argument_test.sv -----
// Self-checking bench for the table arctangent block: random and directed
// operand pairs, degree and radian modes, random stalls on both channels.
// Depends on tata_pkg, tata_if and the RTL top level.
module table_arctangent_two_argument_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tata_pkg::*;

    typedef struct {
        logic signed [31:0] num;
        logic signed [31:0] den;
    } t_operands;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tata_in_if  in_ch();
    tata_out_if out_ch();
    tata_cfg_if cfg_ch();

    table_arctangent_two_argument dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #5 i_clk = ~i_clk;

    t_operands           pending_ops[$];
    logic [ANG_W-1:0]    expected_angles[$];
    logic                radians_mode = 1'b0;
    logic                idle_on = 1'b1;
    logic                hold_out = 1'b0;
    int                  in_gap = 0;
    int                  out_gap = 0;
    int                  mismatches = 0;
    longint              cycle_count = 0;

    function automatic longint tan_entry(int i);
        if (i > 44) return longint'(1) << 16;
        return longint'(TAN_TBL[i] >> 16);
    endfunction

    function automatic longint floor_div_pow(longint x, int s);
        if (x >= 0) return x >>> s;
        return -((-(x + 1)) >>> s) - 1;
    endfunction

    function automatic logic [ANG_W-1:0] predict_angle(logic signed [31:0] y,
                                                       logic signed [31:0] x,
                                                       logic rad);
        longint deg, my, mx, r, v, lo, diff, slope, qr, pi_fix;
        int     i;
        logic   over;
        if (x == 0) begin
            deg = y[31] ? -(longint'(90) << 16) : (longint'(90) << 16);
        end else begin
            my = y[31] ? (longint'(1) << 32) - longint'({1'b0, y}) : longint'(y);
            mx = x[31] ? (longint'(1) << 32) - longint'({1'b0, x}) : longint'(x);
            r = (my << 16) / mx;
            if (r > 64'h7FFFFFFF) r = 64'h7FFFFFFF;
            over = (r >= (longint'(1) << 16));
            v = over ? (longint'(1) << 32) / r : r;
            i = 0;
            while (i < 44 && tan_entry(i + 1) <= v) i++;
            lo = tan_entry(i);
            diff = tan_entry(i + 1) - lo;
            slope = (diff > 0) ? (longint'(1) << 32) / diff : 0;
            deg = longint'(i) * 65536 + floor_div_pow(slope * (v - lo), 16);
            if (over) deg = (longint'(90) << 16) - deg;
            if (!y[31] && !x[31]) deg = deg;
            else if (!y[31]) deg = (longint'(180) << 16) - deg;
            else if (x[31]) deg = deg - (longint'(180) << 16);
            else deg = -deg;
        end
        if (rad) begin
            pi_fix = longint'(64'h3243F6A8885A308D >> 44);
            qr = (deg * 65536) / (longint'(180) << 16);
            deg = floor_div_pow(pi_fix * qr, 16);
        end
        return deg[ANG_W-1:0];
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.numerator <= '0;
            in_ch.denominator <= '0;
            in_gap <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                in_gap <= $urandom_range(1, 14) - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                t_operands op;
                op = pending_ops.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.numerator <= op.num;
                in_ch.denominator <= op.den;
                expected_angles.push_back(predict_angle(op.num, op.den, radians_mode));
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_angles.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected angle %h", out_ch.angle);
                end else begin
                    logic [ANG_W-1:0] want;
                    want = expected_angles.pop_front();
                    if (want !== out_ch.angle) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("angle mismatch: expected %h got %h", want,
                                     out_ch.angle);
                    end
                end
            end
            if (hold_out) begin
                out_ch.ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_gap <= $urandom_range(1, 14) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 3000000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add_pair(logic signed [31:0] n, logic signed [31:0] d);
        t_operands op;
        op.num = n;
        op.den = d;
        pending_ops.push_back(op);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() > 0 || in_ch.valid || expected_angles.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_radians(logic val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.angle_in_radians <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        radians_mode = val;
    endtask

    task automatic add_random(int count);
        logic signed [31:0] n, d;
        for (int k = 0; k < count; k++) begin
            n = $urandom;
            d = $urandom;
            case ($urandom_range(0, 7))
                0: n = n >>> $urandom_range(0, 31);
                1: d = d >>> $urandom_range(0, 31);
                2: d = 0;
                3: n = d + $signed($urandom_range(0, 6)) - 3;
                4: n = 32'sh80000000;
                5: d = 32'sh80000000;
                default: ;
            endcase
            add_pair(n, d);
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.numerator = '0;
        in_ch.denominator = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.angle_in_radians = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int m = 0; m < 2; m++) begin
            if (m == 1) write_radians(1'b1);
            add_pair(0, 0);
            add_pair(5, 0);
            add_pair(-5, 0);
            add_pair(32'sh7FFFFFFF, 1);
            add_pair(32'sh80000000, 1);
            add_pair(1, 32'sh7FFFFFFF);
            add_pair(1, 32'sh80000000);
            add_pair(32'sh80000000, 32'sh80000000);
            add_pair(100, 100);
            add_pair(-100, 100);
            add_pair(100, -100);
            add_pair(-100, -100);
            add_pair(0, -7);
            add_pair(0, 7);
            add_pair(3, 4);
            add_pair(-4, 3);
            wait_drained();
        end
        write_radians(1'b0);

        // long receiver hold-off so the input backs up
        hold_out = 1'b1;
        add_random(20);
        repeat (2000) @(posedge i_clk);
        hold_out = 1'b0;
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_radians(ph[0]);
            add_random(330);
            wait_drained();
        end

        idle_on = 1'b0;
        write_radians(1'b1);
        add_random(100);
        wait_drained();

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
